// ===== rtl/stt_pkg.sv =====
// types, token codes and reserved word tables of the source text tokenizer
package stt_pkg;

   localparam int MAX_LEXEME_DEF = 64;
   localparam int NUM_WORDS = 26;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [4:0] K_IDENT  = 5'd1;
   localparam logic [4:0] K_SEMI   = 5'd2;
   localparam logic [4:0] K_COMMA  = 5'd3;
   localparam logic [4:0] K_COLON  = 5'd4;
   localparam logic [4:0] K_LPAR   = 5'd9;
   localparam logic [4:0] K_RPAR   = 5'd10;
   localparam logic [4:0] K_LBRACE = 5'd11;
   localparam logic [4:0] K_RBRACE = 5'd12;
   localparam logic [4:0] K_ASSIGN = 5'd13;
   localparam logic [4:0] K_OPER   = 5'd14;
   localparam logic [4:0] K_REL    = 5'd16;
   localparam logic [4:0] K_INT    = 5'd17;
   localparam logic [4:0] K_REAL   = 5'd18;
   localparam logic [4:0] K_ERROR  = 5'd26;
   localparam logic [4:0] K_END    = 5'd27;

   localparam logic [NUM_WORDS-1:0] ALL_WORDS = '1;

   localparam logic [95:0] WORD_TEXT [NUM_WORDS] = '{
      96'("Union"), 96'("Intersection"), 96'("Pos"), 96'("Element"), 96'("Quantity"),
      96'("begin"), 96'("end"), 96'("procedure"), 96'("function"), 96'("read"),
      96'("write"), 96'("for"), 96'("repeat"), 96'("while"), 96'("if"), 96'("var"),
      96'("program"), 96'("integer"), 96'("real"), 96'("bagOfInteger"),
      96'("bagOfReal"), 96'("to"), 96'("do"), 96'("until"), 96'("then"), 96'("else")
   };
   localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
      4'd5, 4'd12, 4'd3, 4'd7, 4'd8, 4'd5, 4'd3, 4'd9, 4'd8, 4'd4, 4'd5, 4'd3, 4'd6,
      4'd5, 4'd2, 4'd3, 4'd7, 4'd7, 4'd4, 4'd12, 4'd9, 4'd2, 4'd2, 4'd5, 4'd4, 4'd4
   };
   localparam logic [4:0] WORD_KIND [NUM_WORDS] = '{
      5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd5, 5'd6, 5'd7, 5'd8, 5'd19, 5'd20, 5'd21,
      5'd22, 5'd23, 5'd24, 5'd25, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0
   };

   typedef enum logic [8:0] {
      MODE_IDLE  = 9'b000000001,
      MODE_LT    = 9'b000000010,
      MODE_SLASH = 9'b000000100,
      MODE_COLGT = 9'b000001000,
      MODE_WORD  = 9'b000010000,
      MODE_ZERO  = 9'b000100000,
      MODE_ZFRAC = 9'b001000000,
      MODE_NUM   = 9'b010000000,
      MODE_SIGN  = 9'b100000000
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] start;
      logic [5:0]  length;
      logic        last;
   } token_type;

   typedef struct packed {
      logic      one;
      logic      two;
      token_type tok0;
      token_type tok1;
   } push_type;

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || c == 8'h0a || c == 8'h09;
   endfunction

   // keep the words whose character at idx equals c
   function automatic logic [NUM_WORDS-1:0] narrow_words(logic [NUM_WORDS-1:0] cand,
                                                         logic [7:0] c, logic [7:0] idx);
      logic [NUM_WORDS-1:0] r;
      logic [3:0] p;
      r = '0;
      for (int j = 0; j < NUM_WORDS; j++) begin
         p = WORD_LEN[j] - 4'd1 - idx[3:0];
         if (cand[j] && idx < {4'd0, WORD_LEN[j]})
            r[j] = (WORD_TEXT[j][{p, 3'b000} +: 8] == c);
      end
      return r;
   endfunction

   function automatic logic [4:0] word_kind(logic [NUM_WORDS-1:0] cand, logic [7:0] len);
      logic [4:0] k;
      k = K_IDENT;
      for (int j = NUM_WORDS - 1; j >= 0; j--)
         if (cand[j] && len == {4'd0, WORD_LEN[j]})
            k = WORD_KIND[j];
      return k;
   endfunction

endpackage

// ===== rtl/stt_fifo.sv =====
// token queue between the scanner and the result channel
module stt_fifo (
   input  logic              clock,
   input  logic              reset,
   input  stt_pkg::push_type push,
   output logic              room,
   output logic [2:0]        level,
   output logic              out_valid,
   input  logic              out_ready,
   output stt_pkg::token_type out_tok
);
   import stt_pkg::*;

   token_type  mem_ff [QUEUE_DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = cnt_ff != 3'd0;
   assign out_tok   = mem_ff[rd_ff];
   assign room      = cnt_ff <= 3'd2;
   assign level     = cnt_ff;

   always_comb begin
      wr_in  = wr_ff + {1'b0, push.one} + {1'b0, push.two};
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {2'b0, push.one} + {2'b0, push.two} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push.one)
         mem_ff[wr_ff] <= push.tok0;
      if (push.two)
         mem_ff[wr_ff + 2'd1] <= push.tok1;
   end
endmodule

// ===== rtl/stt_scan.sv =====
// scanner state and per-character token decisions
module stt_scan #(
   parameter int MAX_LEXEME = stt_pkg::MAX_LEXEME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_code,
   input  logic              end_of_input,
   output stt_pkg::push_type push
);
   import stt_pkg::*;

   localparam int CW = $clog2(MAX_LEXEME);

   mode_type             mode_ff, mode_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [31:0]          pos_ff, pos_in, begin_ff, begin_in;
   logic [NUM_WORDS-1:0] cand_ff, cand_in;
   logic [7:0]           first_ff, first_in;
   logic                 point_ff, point_in;

   logic                 va, vb, absorbed, err_close, fin_valid, ovf;
   logic [4:0]           fin_kind;
   token_type            ta, tb;
   logic [7:0]           c;

   assign c   = char_code;
   assign ovf = count_ff == CW'(MAX_LEXEME - 1);

   always_comb begin
      fin_valid = 1'b1;
      fin_kind  = K_OPER;
      case (mode_ff)
         MODE_LT:    fin_kind = K_REL;
         MODE_SLASH: fin_kind = K_OPER;
         MODE_COLGT: fin_kind = (first_ff == ":") ?
                        ((count_ff == CW'(2)) ? K_ASSIGN : K_COLON) : K_REL;
         MODE_WORD:  fin_kind = word_kind(cand_ff, 8'(count_ff));
         MODE_ZERO:  fin_kind = K_INT;
         MODE_ZFRAC: fin_kind = K_REAL;
         MODE_NUM:   fin_kind = point_ff ? K_REAL : K_INT;
         MODE_SIGN:  fin_kind = K_OPER;
         default:    fin_valid = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      cand_in   = cand_ff;
      first_in  = first_ff;
      point_in  = point_ff;
      va        = 1'b0;
      vb        = 1'b0;
      absorbed  = 1'b0;
      err_close = 1'b0;
      ta        = '{kind: fin_kind, start: begin_ff, length: 6'(count_ff), last: 1'b0};
      tb        = '{kind: K_END, start: pos_ff, length: 6'd0, last: 1'b0};
      if (end_of_input) begin
         va      = fin_valid;
         vb      = 1'b1;
         mode_in = MODE_IDLE;
      end else begin
         pos_in = pos_ff + 32'd1;
         case (mode_ff)
            MODE_LT, MODE_SLASH, MODE_COLGT: begin
               if ((mode_ff == MODE_LT && (c == "=" || c == ">")) ||
                   (mode_ff == MODE_SLASH && c == "/") ||
                   (mode_ff == MODE_COLGT && c == "=")) begin
                  absorbed = 1'b1;
                  vb       = 1'b1;
                  count_in = CW'(2);
                  mode_in  = MODE_IDLE;
                  tb.start = begin_ff;
                  tb.length = 6'd2;
                  tb.kind  = (mode_ff == MODE_LT) ? K_REL :
                             (mode_ff == MODE_SLASH) ? K_OPER :
                             (first_ff == ":") ? K_ASSIGN : K_REL;
               end
            end
            MODE_WORD, MODE_ZFRAC, MODE_NUM: begin
               if ((mode_ff == MODE_WORD && (is_letter(c) || is_digit(c))) ||
                   (mode_ff == MODE_ZFRAC && is_digit(c)) ||
                   (mode_ff == MODE_NUM && (is_digit(c) || c == "."))) begin
                  if (ovf) begin
                     // too long: close as error, then rescan the character
                     err_close = 1'b1;
                     va        = 1'b1;
                     ta.kind   = K_ERROR;
                  end else begin
                     absorbed = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (mode_ff == MODE_WORD)
                        cand_in = narrow_words(cand_ff, c, 8'(count_ff));
                     if (c == ".")
                        point_in = 1'b1;
                  end
               end
            end
            MODE_ZERO: begin
               if (c == ".") begin
                  absorbed = 1'b1;
                  mode_in  = MODE_ZFRAC;
                  count_in = CW'(2);
               end
            end
            MODE_SIGN: begin
               if (is_space(c)) begin
                  absorbed = 1'b1;
               end else if (is_digit(c)) begin
                  absorbed = 1'b1;
                  mode_in  = MODE_NUM;
                  count_in = CW'(2);
                  point_in = 1'b0;
               end
            end
            default: ;
         endcase
         if (!absorbed) begin
            if (!err_close)
               va = fin_valid;
            mode_in = MODE_IDLE;
            if (!is_space(c)) begin
               begin_in  = pos_ff;
               count_in  = CW'(1);
               tb.start  = pos_ff;
               tb.length = 6'd1;
               case (c)
                  ";":      begin vb = 1'b1; tb.kind = K_SEMI; end
                  ",":      begin vb = 1'b1; tb.kind = K_COMMA; end
                  "(":      begin vb = 1'b1; tb.kind = K_LPAR; end
                  ")":      begin vb = 1'b1; tb.kind = K_RPAR; end
                  "{":      begin vb = 1'b1; tb.kind = K_LBRACE; end
                  "}":      begin vb = 1'b1; tb.kind = K_RBRACE; end
                  "*":      begin vb = 1'b1; tb.kind = K_OPER; end
                  "=":      begin vb = 1'b1; tb.kind = K_REL; end
                  "<":      mode_in = MODE_LT;
                  "/":      mode_in = MODE_SLASH;
                  ":", ">": begin
                     mode_in  = MODE_COLGT;
                     first_in = c;
                  end
                  "0":      mode_in = MODE_ZERO;
                  "+", "-": mode_in = MODE_SIGN;
                  default: begin
                     if (is_letter(c)) begin
                        mode_in = MODE_WORD;
                        cand_in = narrow_words(ALL_WORDS, c, 8'd0);
                     end else if (is_digit(c)) begin
                        mode_in  = MODE_NUM;
                        point_in = 1'b0;
                     end else begin
                        vb      = 1'b1;
                        tb.kind = K_ERROR;
                     end
                  end
               endcase
            end
         end
      end
   end

   // pack the tokens to the front and mark the final one
   always_comb begin
      push.one  = take && (va || vb);
      push.two  = take && va && vb;
      push.tok0 = va ? ta : tb;
      push.tok1 = tb;
      push.tok0.last = !(va && vb);
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         pos_ff   <= '0;
         begin_ff <= '0;
         cand_ff  <= ALL_WORDS;
         first_ff <= '0;
         point_ff <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         cand_ff  <= cand_in;
         first_ff <= first_in;
         point_ff <= point_in;
      end
   end
endmodule

// ===== rtl/source_text_tokenizer_core.sv =====
// top level of the character-serial source text tokenizer
// One character (or end-of-input mark) is taken per cycle while req_ready is high; the scanner
// decides in the same cycle and writes zero, one or two tokens into a four-entry token queue that
// drives the rsp_ port. req_ready is high while the queue has at least two free entries, so items
// flow back to back as long as tokens drain; the rsp_ side delivers at most one token per cycle,
// which sets the sustained rate when characters produce more than one token each.
module source_text_tokenizer_core #(
   parameter int MAX_LEXEME = stt_pkg::MAX_LEXEME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [5:0]  rsp_token_length,
   output logic        rsp_last_of_run
);
   import stt_pkg::*;

   push_type   push;
   token_type  out_tok;
   logic       room, take;
   logic [2:0] level;

   assign req_ready = room;
   assign take      = req_valid && req_ready;

   stt_scan #(.MAX_LEXEME(MAX_LEXEME)) u_scan (
      .clock(clock), .reset(reset), .take(take), .char_code(req_char_code),
      .end_of_input(req_end_of_input), .push(push)
   );

   stt_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .room(room), .level(level),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_tok(out_tok)
   );

   assign rsp_token_kind   = out_tok.kind;
   assign rsp_token_start  = out_tok.start;
   assign rsp_token_length = out_tok.length;
   assign rsp_last_of_run  = out_tok.last;

   // an end mark always leaves at least its end token queued
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      take && req_end_of_input |=> rsp_valid)
      else $error("end of input produced no token");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level <= 3'(QUEUE_DEPTH))
      else $error("token queue overflow");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.two |-> push.one && !push.tok0.last && push.tok1.last)
      else $error("bad last marking on token pair");
endmodule

// ===== dv/tokenizer_checker.sv =====
// token predictor and checker for the source text tokenizer
module tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_token_kind,
   input  logic [31:0] rsp_token_start,
   input  logic [5:0]  rsp_token_length,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          tokens_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int LEX_LIMIT = MAX_LEXEME_DEF;

   typedef enum int {SC_IDLE, SC_LT, SC_SLASH, SC_COLGT, SC_WORD, SC_ZERO, SC_ZFRAC,
                     SC_NUM, SC_SIGN} scan_state_type;

   token_type   expected_tokens[$];
   token_type   run_tokens[$];
   scan_state_type scan_state;
   int unsigned lex_len;
   logic [31:0] position;
   logic [31:0] begin_pos;
   logic [NUM_WORDS-1:0] candidates;
   logic [7:0]  opener;
   logic        has_point;

   string word_text[NUM_WORDS] = '{"Union", "Intersection", "Pos", "Element", "Quantity",
      "begin", "end", "procedure", "function", "read", "write", "for", "repeat", "while",
      "if", "var", "program", "integer", "real", "bagOfInteger", "bagOfReal", "to", "do",
      "until", "then", "else"};
   logic [4:0] word_code[NUM_WORDS] = '{5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd5, 5'd6,
      5'd7, 5'd8, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

   function automatic bit letter_char(logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
   endfunction
   function automatic bit digit_char(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction
   function automatic bit blank_char(logic [7:0] c);
      return c == 8'd32 || c == 8'd10 || c == 8'd9;
   endfunction

   function automatic void emit(logic [4:0] kind, logic [31:0] start, int unsigned len);
      token_type t;
      t.kind = kind;
      t.start = start;
      t.length = len[5:0];
      t.last = 1'b0;
      run_tokens.push_back(t);
   endfunction

   function automatic void trim_words(logic [7:0] c, int unsigned idx);
      for (int j = 0; j < NUM_WORDS; j++)
         if (candidates[j] && (idx >= word_text[j].len() || word_text[j][idx] != c))
            candidates[j] = 1'b0;
   endfunction

   function automatic void close_lexeme();
      logic [4:0] kind;
      kind = K_OPER;
      case (scan_state)
         SC_IDLE: return;
         SC_LT: kind = K_REL;
         SC_SLASH, SC_SIGN: kind = K_OPER;
         SC_COLGT: kind = (opener == 8'd58) ? ((lex_len == 2) ? K_ASSIGN : K_COLON) : K_REL;
         SC_WORD: begin
            kind = K_IDENT;
            for (int j = NUM_WORDS - 1; j >= 0; j--)
               if (candidates[j] && word_text[j].len() == lex_len) kind = word_code[j];
         end
         SC_ZERO: kind = K_INT;
         SC_ZFRAC: kind = K_REAL;
         SC_NUM: kind = has_point ? K_REAL : K_INT;
         default: return;
      endcase
      emit(kind, begin_pos, lex_len);
      scan_state = SC_IDLE;
   endfunction

   // extend a word or number, or close it as an over-long error
   function automatic bit lengthen();
      if (lex_len + 1 >= LEX_LIMIT) begin
         emit(K_ERROR, begin_pos, lex_len);
         scan_state = SC_IDLE;
         return 0;
      end
      lex_len++;
      return 1;
   endfunction

   function automatic bit extend(logic [7:0] c);
      int unsigned idx;
      idx = lex_len;
      case (scan_state)
         SC_LT: if (c == 8'd61 || c == 8'd62) begin
            lex_len = 2; close_lexeme(); return 1;
         end
         SC_SLASH: if (c == 8'd47) begin
            lex_len = 2; close_lexeme(); return 1;
         end
         SC_COLGT: if (c == 8'd61) begin
            lex_len = 2; close_lexeme(); return 1;
         end
         SC_WORD: if (letter_char(c) || digit_char(c)) begin
            if (!lengthen()) return 0;
            trim_words(c, idx);
            return 1;
         end
         SC_ZERO: if (c == 8'd46) begin
            scan_state = SC_ZFRAC; lex_len = 2; return 1;
         end
         SC_ZFRAC: if (digit_char(c)) return lengthen();
         SC_NUM: if (digit_char(c) || c == 8'd46) begin
            if (!lengthen()) return 0;
            if (c == 8'd46) has_point = 1'b1;
            return 1;
         end
         SC_SIGN: begin
            if (blank_char(c)) return 1;
            if (digit_char(c)) begin
               scan_state = SC_NUM; lex_len = 2; has_point = 1'b0; return 1;
            end
         end
         default: return 0;
      endcase
      return 0;
   endfunction

   task automatic start_lexeme(logic [7:0] c);
      logic [4:0] single;
      if (blank_char(c)) return;
      begin_pos = position;
      lex_len = 1;
      case (c)
         8'd59: single = K_SEMI;
         8'd44: single = K_COMMA;
         8'd40: single = K_LPAR;
         8'd41: single = K_RPAR;
         8'd123: single = K_LBRACE;
         8'd125: single = K_RBRACE;
         8'd42: single = K_OPER;
         8'd61: single = K_REL;
         8'd60: begin scan_state = SC_LT; return; end
         8'd47: begin scan_state = SC_SLASH; return; end
         8'd58, 8'd62: begin scan_state = SC_COLGT; opener = c; return; end
         8'd48: begin scan_state = SC_ZERO; return; end
         8'd43, 8'd45: begin scan_state = SC_SIGN; return; end
         default: begin
            if (letter_char(c)) begin
               scan_state = SC_WORD;
               candidates = '1;
               trim_words(c, 0);
               return;
            end
            if (digit_char(c)) begin
               scan_state = SC_NUM; has_point = 1'b0; return;
            end
            single = K_ERROR;
         end
      endcase
      emit(single, begin_pos, 1);
   endtask

   task automatic predict_tokens(logic [7:0] c, logic eoi);
      run_tokens.delete();
      if (eoi) begin
         close_lexeme();
         emit(K_END, position, 0);
      end else begin
         if (scan_state == SC_IDLE || !extend(c)) begin
            close_lexeme();
            start_lexeme(c);
         end
         position++;
      end
      if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last = 1'b1;
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         scan_state = SC_IDLE; lex_len = 0; position = '0; begin_pos = '0;
         candidates = '1; opener = '0; has_point = 1'b0;
         expected_tokens.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               report("unexpected token kind", rsp_token_kind, 0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind) report("kind", rsp_token_kind, want.kind);
               if (rsp_token_start !== want.start) report("start", rsp_token_start, want.start);
               if (rsp_token_length !== want.length)
                  report("length", rsp_token_length, want.length);
               if (rsp_last_of_run !== want.last) report("last", rsp_last_of_run, want.last);
            end
         end
         if (req_valid && req_ready) predict_tokens(req_char_code, req_end_of_input);
      end
      tokens_pending = expected_tokens.size();
   end
endmodule

// ===== dv/tb.sv =====
// testbench top: stimulus, flow control and verdict for the source text tokenizer
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_code;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_token_kind;
   logic [31:0] rsp_token_start;
   logic [5:0]  rsp_token_length;
   logic        rsp_last_of_run;
   int          fail_count;
   int          tokens_pending;
   int          cycle_count;
   bit          hold_off;
   bit          stim_done;

   typedef struct {logic [7:0] c; logic eoi;} char_item_type;
   char_item_type source_chars[$];

   source_text_tokenizer_core dut (.*);

   tokenizer_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout");
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) source_chars.push_back('{s[i], 1'b0});
   endtask

   task automatic add_run(string alphabet, int n);
      for (int i = 0; i < n; i++)
         source_chars.push_back('{alphabet[$urandom_range(alphabet.len()-1)], 1'b0});
   endtask

   task automatic add_blank();
      string b;
      b = " \n\t";
      source_chars.push_back('{b[$urandom_range(2)], 1'b0});
   endtask

   task automatic add_random_lexeme();
      string kw[$];
      kw = '{"Union", "Intersection", "Pos", "Element", "Quantity", "begin", "end",
             "procedure", "function", "read", "write", "for", "repeat", "while", "if",
             "var", "program", "integer", "real", "bagOfInteger", "bagOfReal", "to", "do",
             "until", "then", "else", "Unio", "ends", "If", "<=", "<>", ">=", ":=", "//",
             ";", ",", "(", ")", "{", "}", "*", "=", "<", ">", ":", "/"};
      case ($urandom_range(9))
         0, 1, 2: add_text(kw[$urandom_range(kw.size()-1)]);
         3: begin
            add_run("abcXYZ", 1);
            add_run("abcdefghijklmnopqrstuvwxyzABCZ0189", $urandom_range(0, 8));
         end
         4: begin
            add_run("123456789", 1);
            add_run("0123456789.", $urandom_range(0, 5));
         end
         5: begin
            add_text("0");
            if ($urandom_range(1)) begin
               add_text(".");
               add_run("0123456789", $urandom_range(4));
            end
         end
         6: begin
            add_run("+-", 1);
            repeat ($urandom_range(2)) add_blank();
            if ($urandom_range(2) != 0) add_run("0123456789.", $urandom_range(1, 4));
         end
         7: source_chars.push_back('{8'($urandom), 1'b0});
         8: source_chars.push_back('{8'($urandom), 1'($urandom_range(5) == 0)});
         default: add_blank();
      endcase
   endtask

   // long words and numbers near the lexeme limit
   task automatic add_long(int n);
      add_text("x");
      add_run("abz09", n - 1);
      add_text(" ");
      add_text("7");
      add_run("0123456789", n - 1);
      add_text(";");
   endtask

   initial begin
      int gap;
      int burst;
      req_valid = 1'b0;
      req_char_code = '0;
      req_end_of_input = 1'b0;
      reset = 1'b1;
      stim_done = 1'b0;
      add_text("program x1;begin a:=0.5+ 12 <= b<>c >= d // e / f end");
      source_chars.push_back('{8'hff, 1'b0});
      source_chars.push_back('{8'h0d, 1'b0});
      source_chars.push_back('{8'h00, 1'b0});
      add_text("- x 0 0. bagOfReal");
      source_chars.push_back('{8'h00, 1'b1});
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      add_long(63);
      add_long(64);
      add_long(62);
      for (int i = 0; i < 8; i++) source_chars.push_back('{8'(1 << i), 1'b0});
      source_chars.push_back('{8'h55, 1'b1});
      while (source_chars.size() < 700) begin
         add_random_lexeme();
         if ($urandom_range(1)) add_blank();
      end
      source_chars.push_back('{8'h00, 1'b1});
      while (source_chars.size() > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && source_chars.size() > 0) begin
            req_valid <= 1'b1;
            req_char_code <= source_chars[0].c;
            req_end_of_input <= source_chars[0].eoi;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            @(negedge clock);
            void'(source_chars.pop_front());
            burst--;
         end
         gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0 || source_chars.size() == 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      stim_done = 1'b1;
      while (tokens_pending > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && tokens_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // long receiver stall early in the run so the token queue fills
   initial begin
      hold_off = 1'b1;
      @(negedge reset);
      repeat (150) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int phase;
      rsp_ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_off) rsp_ready <= 1'b0;
         else if ((phase / 200) % 2 == 1) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(3) != 0);
      end
   end
endmodule
